// File: hdl/tilt_pkg.sv
// Shared types, constants and tables for the tilt angle unit.
// No dependencies.
`timescale 1ns / 1ps

package tilt_pkg;

   localparam int AXIS_W      = 13;  // raw sample width
   localparam int OFS_W       = 10;  // offset register width
   localparam int CAX_W       = 14;  // corrected axis width
   localparam int ABS_W       = 13;  // |corrected axis|, max 4607
   localparam int SQ_W        = 26;  // a^2 + b^2
   localparam int RAD_W       = 58;  // radicand = sq << 32
   localparam int ROOT_W      = 29;
   localparam int REM_W       = 32;
   localparam int SQRT_STEPS  = RAD_W / 2;
   localparam int CW          = 34;  // CORDIC x / y width
   localparam int ANG_W       = 33;  // Q30 angle, signed
   localparam int DEG_W       = 8;
   localparam int ANGLE_ITERATIONS_DEF = 24;
   localparam int ITER_MAX    = 32;

   // deg = floor(floor(ang * 9000 / 2^30) / 157), the /157 by reciprocal
   localparam int DEG_NUM     = 9000;
   localparam int RECIP_157   = 26716;   // ceil(2^22 / 157)
   localparam int RECIP_SH    = 22;
   localparam int DEG_MAX     = 90;

   localparam int CSR_ADDR_W  = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_OFFSET_X = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_OFFSET_Y = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_OFFSET_Z = 2'd2;

   typedef struct packed {
      logic valid;
      logic tag;    // degenerate flag riding along
      logic neg;    // numerator sign
      logic nz;     // numerator nonzero
      logic sqz;    // denominator zero
   } side_type;

   // round(atan(2^-i) * 2^30)
   function automatic logic [ANG_W-1:0] atan_entry(input int i);
      logic [ANG_W-1:0] r;
      case (i)
         0:  r = 33'd843314857;
         1:  r = 33'd497837830;
         2:  r = 33'd263043837;
         3:  r = 33'd133525159;
         4:  r = 33'd67021687;
         5:  r = 33'd33543516;
         6:  r = 33'd16775851;
         7:  r = 33'd8388437;
         8:  r = 33'd4194283;
         9:  r = 33'd2097149;
         default: begin
            if (i >= 10 && i <= 30) r = ANG_W'(1) << (30 - i);
            else r = '0;
         end
      endcase
      return r;
   endfunction

endpackage

// File: hdl/tilt_sqrt_cell.sv
// One digit of the pipelined integer square root (two radicand bits per cell).
// Depends on tilt_pkg.
`timescale 1ns / 1ps

module tilt_sqrt_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  tilt_pkg::side_type           side_i,
   input  logic [tilt_pkg::ABS_W-1:0]   absn_i,
   input  logic [tilt_pkg::RAD_W-1:0]   rad_i,
   input  logic [tilt_pkg::REM_W-1:0]   rem_i,
   input  logic [tilt_pkg::ROOT_W-1:0]  root_i,
   output tilt_pkg::side_type           side_o,
   output logic [tilt_pkg::ABS_W-1:0]   absn_o,
   output logic [tilt_pkg::RAD_W-1:0]   rad_o,
   output logic [tilt_pkg::REM_W-1:0]   rem_o,
   output logic [tilt_pkg::ROOT_W-1:0]  root_o
);
   import tilt_pkg::*;

   side_type          side_ff;
   logic [ABS_W-1:0]  absn_ff;
   logic [RAD_W-1:0]  rad_ff;
   logic [REM_W-1:0]  rem_ff, rem_in, rem_sh;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [REM_W-1:0]  trial;

   always_comb begin
      rem_sh = {rem_i[REM_W-3:0], rad_i[RAD_W-1 -: 2]};
      trial  = {1'b0, root_i, 2'b01};
      if (rem_sh >= trial) begin
         rem_in  = rem_sh - trial;
         root_in = {root_i[ROOT_W-2:0], 1'b1};
      end else begin
         rem_in  = rem_sh;
         root_in = {root_i[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else if (en) begin
         side_ff.valid <= side_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff.tag <= side_i.tag;
         side_ff.neg <= side_i.neg;
         side_ff.nz  <= side_i.nz;
         side_ff.sqz <= side_i.sqz;
         absn_ff     <= absn_i;
         rad_ff      <= {rad_i[RAD_W-3:0], 2'b00};
         rem_ff      <= rem_in;
         root_ff     <= root_in;
      end
   end

   assign side_o = side_ff;
   assign absn_o = absn_ff;
   assign rad_o  = rad_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;

endmodule

// File: hdl/tilt_cordic_cell.sv
// One vectoring micro-rotation of the pipelined CORDIC.
// Depends on tilt_pkg.
`timescale 1ns / 1ps

module tilt_cordic_cell #(
   parameter int SHIFT = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  tilt_pkg::side_type                side_i,
   input  logic signed [tilt_pkg::CW-1:0]    x_i,
   input  logic signed [tilt_pkg::CW-1:0]    y_i,
   input  logic signed [tilt_pkg::ANG_W-1:0] ang_i,
   output tilt_pkg::side_type                side_o,
   output logic signed [tilt_pkg::CW-1:0]    x_o,
   output logic signed [tilt_pkg::CW-1:0]    y_o,
   output logic signed [tilt_pkg::ANG_W-1:0] ang_o
);
   import tilt_pkg::*;

   localparam logic signed [ANG_W-1:0] STEP = atan_entry(SHIFT);

   side_type                side_ff;
   logic signed [CW-1:0]    x_ff, x_in, y_ff, y_in;
   logic signed [ANG_W-1:0] ang_ff, ang_in;
   logic signed [CW-1:0]    xs, ys;

   always_comb begin
      xs = x_i >>> SHIFT;
      ys = y_i >>> SHIFT;
      if (!y_i[CW-1]) begin
         x_in   = x_i + ys;
         y_in   = y_i - xs;
         ang_in = ang_i + STEP;
      end else begin
         x_in   = x_i - ys;
         y_in   = y_i + xs;
         ang_in = ang_i - STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else if (en) begin
         side_ff.valid <= side_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff.tag <= side_i.tag;
         side_ff.neg <= side_i.neg;
         side_ff.nz  <= side_i.nz;
         side_ff.sqz <= side_i.sqz;
         x_ff        <= x_in;
         y_ff        <= y_in;
         ang_ff      <= ang_in;
      end
   end

   assign side_o = side_ff;
   assign x_o    = x_ff;
   assign y_o    = y_ff;
   assign ang_o  = ang_ff;

endmodule

// File: hdl/tilt_lane.sv
// One angle: atan(n / sqrt(a^2 + b^2)) in whole degrees, fully pipelined.
// Depends on tilt_pkg, tilt_sqrt_cell, tilt_cordic_cell.
`timescale 1ns / 1ps

module tilt_lane #(
   parameter int ANGLE_ITERATIONS = tilt_pkg::ANGLE_ITERATIONS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              valid_i,
   input  logic                              tag_i,
   input  logic signed [tilt_pkg::CAX_W-1:0] n_i,
   input  logic signed [tilt_pkg::CAX_W-1:0] a_i,
   input  logic signed [tilt_pkg::CAX_W-1:0] b_i,
   output logic                              valid_o,
   output logic                              tag_o,
   output logic signed [tilt_pkg::DEG_W-1:0] deg_o
);
   import tilt_pkg::*;

   localparam int PROD_W = 45;
   localparam int VQ_W   = 15;
   localparam int Q_W    = 30;

   // squares
   side_type                sa_ff;
   logic signed [CAX_W-1:0] n_ff;
   logic [2*CAX_W-3:0]      a2_ff, b2_ff;
   // sum and flags
   side_type                sb_ff, sb_in;
   logic [ABS_W-1:0]        absn_ff;
   logic [SQ_W-1:0]         sq_ff, sq_in;

   always_comb begin
      sq_in       = SQ_W'({1'b0, a2_ff} + {1'b0, b2_ff});
      sb_in       = sa_ff;
      sb_in.neg   = n_ff[CAX_W-1];
      sb_in.nz    = (n_ff != '0);
      sb_in.sqz   = (sq_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_ff.valid <= 1'b0;
         sb_ff.valid <= 1'b0;
      end else if (en) begin
         sa_ff.valid <= valid_i;
         sb_ff.valid <= sa_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sa_ff.tag <= tag_i;
         sa_ff.neg <= 1'b0;
         sa_ff.nz  <= 1'b0;
         sa_ff.sqz <= 1'b0;
         n_ff      <= n_i;
         a2_ff     <= (2*CAX_W-2)'(a_i * a_i);
         b2_ff     <= (2*CAX_W-2)'(b_i * b_i);
         sb_ff.tag <= sb_in.tag;
         sb_ff.neg <= sb_in.neg;
         sb_ff.nz  <= sb_in.nz;
         sb_ff.sqz <= sb_in.sqz;
         absn_ff   <= ABS_W'(n_ff[CAX_W-1] ? -n_ff : n_ff);
         sq_ff     <= sq_in;
      end
   end

   // square root chain
   side_type          qs   [SQRT_STEPS+1];
   logic [ABS_W-1:0]  qabs [SQRT_STEPS+1];
   logic [RAD_W-1:0]  qrad [SQRT_STEPS+1];
   logic [REM_W-1:0]  qrem [SQRT_STEPS+1];
   logic [ROOT_W-1:0] qroot[SQRT_STEPS+1];

   assign qs[0]    = sb_ff;
   assign qabs[0]  = absn_ff;
   assign qrad[0]  = {sq_ff, (RAD_W-SQ_W)'(0)};
   assign qrem[0]  = '0;
   assign qroot[0] = '0;

   for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_sqrt
      tilt_sqrt_cell u_cell (
         .clock (clock),  .reset (reset),  .en (en),
         .side_i(qs[s]),  .absn_i(qabs[s]), .rad_i(qrad[s]),
         .rem_i (qrem[s]), .root_i(qroot[s]),
         .side_o(qs[s+1]), .absn_o(qabs[s+1]), .rad_o(qrad[s+1]),
         .rem_o (qrem[s+1]), .root_o(qroot[s+1])
      );
   end

   // CORDIC chain, X = sqrt in Q16, Y = |n| in Q16
   side_type                cs [ANGLE_ITERATIONS+1];
   logic signed [CW-1:0]    cx [ANGLE_ITERATIONS+1];
   logic signed [CW-1:0]    cy [ANGLE_ITERATIONS+1];
   logic signed [ANG_W-1:0] ca [ANGLE_ITERATIONS+1];

   assign cs[0] = qs[SQRT_STEPS];
   assign cx[0] = CW'(qroot[SQRT_STEPS]);
   assign cy[0] = CW'({qabs[SQRT_STEPS], 16'h0000});
   assign ca[0] = '0;

   for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_cordic
      tilt_cordic_cell #(.SHIFT(i)) u_cell (
         .clock (clock), .reset (reset), .en (en),
         .side_i(cs[i]), .x_i(cx[i]), .y_i(cy[i]), .ang_i(ca[i]),
         .side_o(cs[i+1]), .x_o(cx[i+1]), .y_o(cy[i+1]), .ang_o(ca[i+1])
      );
   end

   // radians to degrees
   side_type                sd_ff, se_ff, sf_ff;
   logic [PROD_W-1:0]       prod_ff;
   logic [Q_W-1:0]          q_ff;
   logic signed [DEG_W-1:0] deg_ff, deg_in;
   logic [ANG_W-2:0]        ang_pos;
   logic [DEG_W-1:0]        deg_raw, deg_mag;

   assign ang_pos = ca[ANGLE_ITERATIONS][ANG_W-1] ? '0 : ca[ANGLE_ITERATIONS][ANG_W-2:0];

   always_comb begin
      deg_raw = q_ff[Q_W-1 -: DEG_W];
      if (!se_ff.nz)                deg_mag = '0;
      else if (se_ff.sqz)           deg_mag = DEG_W'(DEG_MAX);
      else if (deg_raw > DEG_MAX)   deg_mag = DEG_W'(DEG_MAX);
      else                          deg_mag = deg_raw;
      deg_in = se_ff.neg ? -$signed(deg_mag) : $signed(deg_mag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sd_ff.valid <= 1'b0;
         se_ff.valid <= 1'b0;
         sf_ff.valid <= 1'b0;
      end else if (en) begin
         sd_ff.valid <= cs[ANGLE_ITERATIONS].valid;
         se_ff.valid <= sd_ff.valid;
         sf_ff.valid <= se_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sd_ff.tag <= cs[ANGLE_ITERATIONS].tag;
         sd_ff.neg <= cs[ANGLE_ITERATIONS].neg;
         sd_ff.nz  <= cs[ANGLE_ITERATIONS].nz;
         sd_ff.sqz <= cs[ANGLE_ITERATIONS].sqz;
         prod_ff   <= PROD_W'(ang_pos * PROD_W'(DEG_NUM));
         se_ff.tag <= sd_ff.tag;
         se_ff.neg <= sd_ff.neg;
         se_ff.nz  <= sd_ff.nz;
         se_ff.sqz <= sd_ff.sqz;
         q_ff      <= Q_W'(prod_ff[PROD_W-1 -: VQ_W] * Q_W'(RECIP_157));
         sf_ff.tag <= se_ff.tag;
         sf_ff.neg <= se_ff.neg;
         sf_ff.nz  <= se_ff.nz;
         sf_ff.sqz <= se_ff.sqz;
         deg_ff    <= deg_in;
      end
   end

   assign valid_o = sf_ff.valid;
   assign tag_o   = sf_ff.tag;
   assign deg_o   = deg_ff;

endmodule

// File: hdl/accel_tilt_angles_unit.sv
// Top level: offset correction, roll and pitch lanes, stream handshakes.
// Depends on tilt_pkg, tilt_lane.
`timescale 1ns / 1ps
//
//  channel   dir  handshake              payload
//  req_      in   tvalid/tready          tdata: x_raw, y_raw, z_raw (13b each)
//  rsp_      out  tvalid/tready          tdata: roll_deg, pitch_deg; tuser: degenerate
//  csr_      in   csr_we (no wait)       csr_addr index, csr_wdata 10b offset
//
//  One sample per cycle unless the output stalls. Pipeline: 1 offset stage,
//  2 square/sum stages, 29 square-root cells, one CORDIC cell per iteration,
//  3 degree-conversion stages, the last being the output register.
//  Reset is synchronous, clears the valid bits and loads the default offsets.
//  A held result stalls the whole pipeline; req_tready drops only then.

module accel_tilt_angles_unit #(
   parameter int ANGLE_ITERATIONS = tilt_pkg::ANGLE_ITERATIONS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [39:0]                         req_tdata,  // x_raw, y_raw, z_raw, pad
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [15:0]                         rsp_tdata,  // roll_deg, pitch_deg
   output logic                                rsp_tuser,  // degenerate
   input  logic                                csr_we,
   input  logic [tilt_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [tilt_pkg::OFS_W-1:0]          csr_wdata
);
   import tilt_pkg::*;

   logic signed [OFS_W-1:0] ofs_x_ff, ofs_y_ff, ofs_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ofs_x_ff <= 10'sd7;
         ofs_y_ff <= 10'sd6;
         ofs_z_ff <= -10'sd10;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_OFFSET_X: ofs_x_ff <= csr_wdata;
            CSR_OFFSET_Y: ofs_y_ff <= csr_wdata;
            CSR_OFFSET_Z: ofs_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic en;
   logic roll_valid, pitch_valid, roll_tag, pitch_tag;
   logic signed [DEG_W-1:0] roll_deg, pitch_deg;

   assign en         = rsp_tready | ~rsp_tvalid;
   assign req_tready = en;

   logic                    v0_ff, degen_ff;
   logic signed [CAX_W-1:0] x_ff, y_ff, z_ff, x_in, y_in, z_in;

   assign x_in = CAX_W'($signed(req_tdata[12:0]))  - CAX_W'(ofs_x_ff);
   assign y_in = CAX_W'($signed(req_tdata[25:13])) - CAX_W'(ofs_y_ff);
   assign z_in = CAX_W'($signed(req_tdata[38:26])) - CAX_W'(ofs_z_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         z_ff     <= z_in;
         degen_ff <= (x_in == '0) && (y_in == '0) && (z_in == '0);
      end
   end

   tilt_lane #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_roll (
      .clock(clock), .reset(reset), .en(en),
      .valid_i(v0_ff), .tag_i(degen_ff),
      .n_i(y_ff), .a_i(x_ff), .b_i(z_ff),
      .valid_o(roll_valid), .tag_o(roll_tag), .deg_o(roll_deg)
   );

   tilt_lane #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_pitch (
      .clock(clock), .reset(reset), .en(en),
      .valid_i(v0_ff), .tag_i(degen_ff),
      .n_i(x_ff), .a_i(y_ff), .b_i(z_ff),
      .valid_o(pitch_valid), .tag_o(pitch_tag), .deg_o(pitch_deg)
   );

   assign rsp_tvalid = roll_valid & pitch_valid;
   assign rsp_tdata  = {pitch_deg, roll_deg};
   assign rsp_tuser  = roll_tag & pitch_tag;

endmodule

// File: hdl/tilt_checker.sv
// Port-level checks on the tilt angle unit, bound to its top level.
// Depends on accel_tilt_angles_unit.
`timescale 1ns / 1ps

module tilt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (rsp_tready || !rsp_tvalid))
      else $error("input ready does not follow output stall");

   a_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 16'h0000)
      else $error("degenerate result with nonzero angles");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[7:0]) >= -8'sd90) && ($signed(rsp_tdata[7:0]) <= 8'sd90)
                  && ($signed(rsp_tdata[15:8]) >= -8'sd90) && ($signed(rsp_tdata[15:8]) <= 8'sd90))
      else $error("angle out of range");

endmodule

bind accel_tilt_angles_unit tilt_checker u_tilt_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
);

// File: sim/tb_accel_tilt_angles_unit.sv
// Self-checking bench for accel_tilt_angles_unit: random and directed samples,
// angles predicted in-bench with integer sqrt + CORDIC. Depends on tilt_pkg.
`timescale 1ns / 1ps

module tb_accel_tilt_angles_unit;
   import tilt_pkg::*;

   localparam int LATENCY = ANGLE_ITERATIONS_DEF + 35;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE = 2'd3;  // unmapped index, write ignored

   typedef struct {
      logic signed [7:0] roll;
      logic signed [7:0] pitch;
      logic              degen;
   } tilt_result_type;

   // round(atan(2^-i) * 2^30)
   localparam longint ATAN_Q30 [0:31] = '{
      843314857, 497837830, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
      16, 8, 4, 2, 1, 0};

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [39:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [15:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_we = 0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [OFS_W-1:0] csr_wdata = '0;

   logic signed [OFS_W-1:0] ofs_x = 10'sd7, ofs_y = 10'sd6, ofs_z = -10'sd10;
   logic [38:0] sample_q[$];       // {z, y, x}
   tilt_result_type angle_q[$];
   int failures = 0;
   int send_idle = 0, recv_idle = 0;
   bit hold_request = 0, hold_done = 0;
   int hold_left = 0;

   accel_tilt_angles_unit dut (.*);

   initial forever #5 clock = ~clock;

   // degrees of atan(n / sqrt(a^2 + b^2)), truncated toward zero
   function automatic longint tilt_degrees(longint n, longint a, longint b);
      longint unsigned sq, rem, root, sq_bit;
      longint cx, cy, ang, xs, ys, deg;
      if (n == 0) return 0;
      sq = a * a + b * b;
      if (sq == 0) return (n > 0) ? 90 : -90;
      rem = sq << 32;
      root = 0;
      sq_bit = 64'd1 << 62;
      while (sq_bit > rem) sq_bit >>= 2;
      while (sq_bit != 0) begin
         if (rem >= root + sq_bit) begin
            rem -= root + sq_bit;
            root = (root >> 1) + sq_bit;
         end else begin
            root >>= 1;
         end
         sq_bit >>= 2;
      end
      cx = root;
      cy = ((n < 0) ? -n : n) * 65536;
      ang = 0;
      for (int i = 0; i < ANGLE_ITERATIONS_DEF; i++) begin
         xs = cx >>> i;
         ys = cy >>> i;
         if (cy >= 0) begin
            cx += ys; cy -= xs; ang += ATAN_Q30[i];
         end else begin
            cx -= ys; cy += xs; ang -= ATAN_Q30[i];
         end
      end
      if (ang < 0) ang = 0;
      deg = (ang * 9000) / (longint'(157) << 30);
      if (deg > 90) deg = 90;
      return (n < 0) ? -deg : deg;
   endfunction

   function automatic tilt_result_type predict_angles(logic [38:0] s);
      tilt_result_type r;
      longint x, y, z;
      x = longint'($signed(s[12:0])) - longint'(ofs_x);
      y = longint'($signed(s[25:13])) - longint'(ofs_y);
      z = longint'($signed(s[38:26])) - longint'(ofs_z);
      r.degen = (x == 0 && y == 0 && z == 0);
      r.roll = r.degen ? 8'sd0 : 8'(tilt_degrees(y, x, z));
      r.pitch = r.degen ? 8'sd0 : 8'(tilt_degrees(x, y, z));
      return r;
   endfunction

   // driver: prediction is made on the transfer itself
   always @(posedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_tready) begin
            if (req_tvalid) angle_q.push_back(predict_angles(req_tdata[38:0]));
            if (sample_q.size() > 0 && $urandom_range(99) >= send_idle) begin
               req_tvalid <= 1'b1;
               req_tdata <= {1'b0, sample_q.pop_front()};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver back-pressure, with one long hold-off on request
   always @(posedge clock) begin
      if (hold_request && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= 400;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // monitor
   always @(posedge clock) begin
      tilt_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (angle_q.size() == 0) begin
            $error("result transfer with no expectation: %h/%b", rsp_tdata, rsp_tuser);
            failures++;
         end else begin
            exp_r = angle_q.pop_front();
            if (rsp_tdata[7:0] !== exp_r.roll) begin
               $error("roll_deg: expected %0d, got %0d", exp_r.roll, $signed(rsp_tdata[7:0]));
               failures++;
            end
            if (rsp_tdata[15:8] !== exp_r.pitch) begin
               $error("pitch_deg: expected %0d, got %0d", exp_r.pitch,
                      $signed(rsp_tdata[15:8]));
               failures++;
            end
            if (rsp_tuser !== exp_r.degen) begin
               $error("degenerate: expected %0b, got %0b", exp_r.degen, rsp_tuser);
               failures++;
            end
         end
      end
   end

   function automatic logic [12:0] axis_value(logic signed [OFS_W-1:0] ofs);
      int pick;
      pick = $urandom_range(99);
      if (pick < 20) return 13'($signed(ofs));        // corrected axis is zero
      if (pick < 25) return 13'h0FFF;
      if (pick < 30) return 13'h1000;
      if (pick < 40) return 13'($signed(ofs)) + 13'($urandom_range(8)) - 13'd4;
      return 13'($urandom);
   endfunction

   task automatic queue_random(int count);
      for (int i = 0; i < count; i++)
         sample_q.push_back({axis_value(ofs_z), axis_value(ofs_y), axis_value(ofs_x)});
   endtask

   task automatic wait_idle();
      while (sample_q.size() > 0 || req_tvalid || angle_q.size() > 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic write_offsets(logic signed [OFS_W-1:0] nx, ny, nz);
      logic [CSR_ADDR_W-1:0] addrs [4];
      logic [OFS_W-1:0] vals [4];
      addrs = '{CSR_OFFSET_X, CSR_OFFSET_Y, CSR_OFFSET_Z, CSR_SPARE};
      vals = '{nx, ny, nz, OFS_W'($urandom)};
      foreach (addrs[i]) begin
         @(posedge clock);
         csr_we <= 1'b1;
         csr_addr <= addrs[i];
         csr_wdata <= vals[i];
      end
      @(posedge clock);
      csr_we <= 1'b0;
      ofs_x = nx; ofs_y = ny; ofs_z = nz;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed, reset offsets 7 / 6 / -10
      send_idle = 11; recv_idle = 61;
      sample_q.push_back({13'h1FF6, 13'd6, 13'd7});           // all-zero vector
      sample_q.push_back({13'h1FF6, 13'd6, 13'd100});          // pitch +90
      sample_q.push_back({13'h1FF6, 13'd6, 13'h1F00});         // pitch -90
      sample_q.push_back({13'h1FF6, 13'd500, 13'd7});          // roll +90
      sample_q.push_back({13'h1FF6, 13'h1E00, 13'd7});         // roll -90
      sample_q.push_back({13'd500, 13'd6, 13'd7});             // z only
      sample_q.push_back({13'h0FFF, 13'h0FFF, 13'h0FFF});
      sample_q.push_back({13'h1000, 13'h1000, 13'h1000});
      sample_q.push_back({13'h0FFF, 13'h1000, 13'h0FFF});
      sample_q.push_back({13'h1000, 13'h0FFF, 13'h1000});
      sample_q.push_back({13'h1FF6, 13'd106, 13'd107});        // 45-degree-ish pair
      sample_q.push_back({13'd90, 13'd6, 13'd107});            // pitch 45
      sample_q.push_back({13'h1FF6, 13'd7, 13'd7});            // tiny numerator
      sample_q.push_back({13'h1FF7, 13'd6, 13'd8});
      sample_q.push_back({13'h0000, 13'h0000, 13'h0000});
      sample_q.push_back({13'h1FFF, 13'h1FFF, 13'h1FFF});
      queue_random(90);
      wait_idle();

      write_offsets(-10'sd512, -10'sd512, -10'sd512);
      queue_random(100);
      wait_idle();
      write_offsets(10'sd511, 10'sd511, 10'sd511);
      queue_random(100);
      wait_idle();

      send_idle = 61; recv_idle = 11;
      write_offsets(10'($urandom), 10'($urandom), 10'($urandom));
      queue_random(100);
      wait_idle();
      write_offsets(10'sd0, 10'sd0, 10'sd0);
      queue_random(100);
      wait_idle();

      send_idle = 0; recv_idle = 0;
      write_offsets(10'($urandom), 10'($urandom), 10'($urandom));
      hold_request = 1;
      queue_random(120);
      wait_idle();

      if (failures == 0) begin
         $display("tb_accel_tilt_angles_unit passed");
      end else begin
         $display("tb_accel_tilt_angles_unit failed");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("tb_accel_tilt_angles_unit failed");
      $finish;
   end

endmodule
